/* rtl/arx_block_cipher_64_128_encrypt_core_macros.svh */
// assertion macros shared by the cipher core rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef ARX_BLOCK_CIPHER_64_128_ENCRYPT_CORE_MACROS_SVH
`define ARX_BLOCK_CIPHER_64_128_ENCRYPT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ARXBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define ARXBC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ARXBC_ASSERT(lbl, prop, msg)
`define ARXBC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/arxbc_pkg.sv */
// types, constants and rotate helper for the 64/128 arx cipher core
// no dependencies
package arxbc_pkg;

	localparam int WORD_W    = 16;
	localparam int DIGIT_W   = 4;
	localparam int NDIG      = WORD_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(NDIG);
	localparam int KEY_WORDS = 8;
	localparam int KIDX_W    = $clog2(KEY_WORDS);
	localparam int RK_DEPTH  = 16;
	localparam int RK_IDX_W  = $clog2(RK_DEPTH);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t plain_word_0;
		word_t plain_word_1;
		word_t plain_word_2;
		word_t plain_word_3;
	} plain_t;

	typedef struct packed {
		word_t cipher_word_0;
		word_t cipher_word_1;
		word_t cipher_word_2;
		word_t cipher_word_3;
	} cipher_t;

	// controls from the sequencer to the round datapath
	typedef struct packed {
		logic start;
		logic step;
		logic last;
		logic cur_odd;
	} round_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// rotate left by a constant amount in 1..WORD_W-1
	function automatic word_t rol(input word_t v, input int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

endpackage

/* rtl/arx_block_cipher_64_128_encrypt_core.sv */
// 64/128 arx block cipher encryption core, top level
// depends on arxbc_pkg, arxbc_key_table, arxbc_round and the macros header
//
// Encrypts one 64-bit word (four 16-bit words) at a time with a 128-bit key
// held as eight 16-bit key words. A key word write updates its two round key
// entries in the same cycle, so a block encrypted between writes uses the
// mix of old and new key words. Each round's 16-bit add runs through a
// 4-bit digit-serial adder, one digit per step; a block is accepted in
// ST_IDLE, runs its rounds in ST_RUN and is moved into the output
// register from ST_DRAIN, which waits while that register is full. ROUNDS
// is 80 by default. The result register frees the input side: the next
// block is taken while the previous ciphertext waits to be read. Key writes
// are allowed only while the core is idle.
`include "arx_block_cipher_64_128_encrypt_core_macros.svh"

module arx_block_cipher_64_128_encrypt_core import arxbc_pkg::*; #(
	parameter int ROUNDS = 80
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plain_valid,
	output logic              plain_ready,
	input  plain_t            plain,
	output logic              cipher_valid,
	input  logic              cipher_ready,
	output cipher_t           cipher,
	input  logic              key_we,
	input  logic [KIDX_W-1:0] key_index,
	input  word_t             key_data
);

	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	state_t                state_q, state_nxt;
	logic [RW-1:0]         round_q;
	logic [DIG_CNT_W-1:0]  digit_q;
	round_ctrl_t           ctrl;
	logic                  last_digit;
	logic                  last_round;
	logic                  slot_free;
	logic                  load_out;
	word_t                 op_round;
	word_t                 rk;
	cipher_t               result;
	cipher_t               cipher_q;
	logic                  cipher_vld_q;

	assign last_digit = (digit_q == DIG_CNT_W'(NDIG - 1));
	assign last_round = (round_q == RW'(ROUNDS - 1));
	assign slot_free  = !cipher_vld_q || cipher_ready;

	// round number for the operands being loaded
	assign op_round = ctrl.start ? '0 : WORD_W'({1'b0, round_q} + (RW + 1)'(1));

	arxbc_key_table u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_we    (key_we),
		.key_index (key_index),
		.key_data  (key_data),
		.rk_index  (op_round[RK_IDX_W-1:0]),
		.rk        (rk)
	);

	arxbc_round u_round (
		.clk      (clk),
		.ctrl     (ctrl),
		.block    (plain),
		.op_round (op_round),
		.rk       (rk),
		.result   (result)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath controls
	always_comb begin
		state_nxt   = state_q;
		ctrl        = '0;
		plain_ready = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				plain_ready = 1'b1;
				if (plain_valid) begin
					ctrl.start = 1'b1;
					state_nxt  = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.step    = 1'b1;
				ctrl.last    = last_digit;
				ctrl.cur_odd = round_q[0];
				if (last_digit && last_round) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (slot_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// round and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			digit_q <= '0;
		end else if (ctrl.start) begin
			round_q <= '0;
			digit_q <= '0;
		end else if (ctrl.step) begin
			if (last_digit) begin
				digit_q <= '0;
				round_q <= round_q + RW'(1);
			end else begin
				digit_q <= digit_q + DIG_CNT_W'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_vld_q <= 1'b0;
		end else if (load_out) begin
			cipher_vld_q <= 1'b1;
		end else if (cipher_ready) begin
			cipher_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) cipher_q <= result;
	end

	assign cipher_valid = cipher_vld_q;
	assign cipher       = cipher_q;

	`ARXBC_ASSERT(a_start_clears, (plain_valid && plain_ready) |=> (round_q == '0 && digit_q == '0 && state_q == ST_RUN), "round counters not cleared at block start")
	`ARXBC_ASSERT(a_finish, (state_q == ST_RUN && last_digit && last_round) |=> (state_q == ST_DRAIN), "final round did not end the run")
	`ARXBC_ASSERT(a_drain_out, (state_q == ST_DRAIN && slot_free) |=> (cipher_valid && state_q == ST_IDLE), "finished word not moved to output")
	`ARXBC_ASSERT_NEVER(a_drain_digit, state_q == ST_DRAIN && digit_q != '0, "digit counter off at end of block")

endmodule

/* rtl/arxbc_key_table.sv */
// round key table: sixteen 16-bit round keys updated on each key word write
// depends on arxbc_pkg
module arxbc_key_table import arxbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_we,
	input  logic [KIDX_W-1:0]   key_index,
	input  word_t               key_data,
	input  logic [RK_IDX_W-1:0] rk_index,
	output word_t               rk
);

	word_t                rk_q [RK_DEPTH];
	word_t                base;
	logic [RK_IDX_W-1:0]  lo_idx;
	logic [RK_IDX_W-1:0]  hi_idx;

	// each key word owns one entry in each half of the table
	assign base   = key_data ^ rol(key_data, 1);
	assign lo_idx = {1'b0, key_index};
	assign hi_idx = {1'b1, key_index[KIDX_W-1:1], ~key_index[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RK_DEPTH; i++) rk_q[i] <= '0;
		end else if (key_we) begin
			rk_q[lo_idx] <= base ^ rol(key_data, 8);
			rk_q[hi_idx] <= base ^ rol(key_data, 11);
		end
	end

	// single read port for the round in progress
	assign rk = rk_q[rk_index];

endmodule

/* rtl/arxbc_round.sv */
// round datapath: four state words and a 4-bit digit-serial adder
// depends on arxbc_pkg
module arxbc_round import arxbc_pkg::*; (
	input  logic        clk,
	input  round_ctrl_t ctrl,
	input  plain_t      block,
	input  word_t       op_round,
	input  word_t       rk,
	output cipher_t     result
);

	word_t              w0_q, w1_q, w2_q, w3_q;
	word_t              a_q, b_q;
	logic               carry_q;
	logic [DIGIT_W:0]   dsum;
	word_t              sum_full;
	word_t              fresh;
	word_t              src0, src1;
	word_t              op_a, op_b;

	// one digit of the add, low digit first; sum shifts in from the top of a_q
	assign dsum     = {1'b0, a_q[DIGIT_W-1:0]} + {1'b0, b_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, carry_q};
	assign sum_full = {dsum[DIGIT_W-1:0], a_q[WORD_W-1:DIGIT_W]};
	assign fresh    = ctrl.cur_odd ? rol(sum_full, 1) : rol(sum_full, 8);

	// operands of the next round come from words that do not depend on the add
	assign src0 = ctrl.start ? block.plain_word_0 : w1_q;
	assign src1 = ctrl.start ? block.plain_word_1 : w2_q;
	assign op_a = src0 ^ op_round;
	assign op_b = (op_round[0] ? rol(src1, 8) : rol(src1, 1)) ^ rk;

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			w0_q    <= block.plain_word_0;
			w1_q    <= block.plain_word_1;
			w2_q    <= block.plain_word_2;
			w3_q    <= block.plain_word_3;
			a_q     <= op_a;
			b_q     <= op_b;
			carry_q <= 1'b0;
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				// round done: shift words and load the next round's operands
				w0_q    <= w1_q;
				w1_q    <= w2_q;
				w2_q    <= w3_q;
				w3_q    <= fresh;
				a_q     <= op_a;
				b_q     <= op_b;
				carry_q <= 1'b0;
			end else begin
				a_q     <= sum_full;
				b_q     <= b_q >> DIGIT_W;
				carry_q <= dsum[DIGIT_W];
			end
		end
	end

	assign result = '{cipher_word_0: w0_q, cipher_word_1: w1_q,
		cipher_word_2: w2_q, cipher_word_3: w3_q};

endmodule

/* tb/sv/arx_cipher_checker.sv */
// checker for the 64/128 arx cipher core: watches key writes and both word channels,
// predicts each ciphertext word and compares it with what the core returns
// depends on arxbc_pkg
`timescale 1ns / 1ps

module arx_cipher_checker import arxbc_pkg::*; #(
	parameter int ROUNDS = 80
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plain_valid,
	input  logic              plain_ready,
	input  plain_t            plain,
	input  logic              cipher_valid,
	input  logic              cipher_ready,
	input  cipher_t           cipher,
	input  logic              key_we,
	input  logic [KIDX_W-1:0] key_index,
	input  word_t             key_data,
	output int                errors,
	output int                pending,
	output int                blocks_checked,
	output int                key_writes
);

	localparam int BLOCK_W = 4 * WORD_W;

	word_t                round_keys [RK_DEPTH];
	cipher_t              expected_ciphers [$];
	cipher_t              want;
	logic [BLOCK_W-1:0]   got_bits;
	logic [BLOCK_W-1:0]   want_bits;
	int                   odd_slot;

	// rotate left, taken from the upper half of the doubled word
	function automatic word_t rotl(input word_t v, input int unsigned s);
		logic [2*WORD_W-1:0] twice;
		twice = {v, v};
		return twice[2*WORD_W-1-s -: WORD_W];
	endfunction

	// full encryption of one block with the current round key table
	function automatic cipher_t encrypt_block(input plain_t p);
		word_t   x0, x1, x2, x3;
		word_t   mixed, sum, fresh;
		cipher_t c;
		x0 = p.plain_word_0;
		x1 = p.plain_word_1;
		x2 = p.plain_word_2;
		x3 = p.plain_word_3;
		for (int r = 0; r < ROUNDS; r++) begin
			if (r % 2 == 0) begin
				mixed = rotl(x1, 1) ^ round_keys[r % RK_DEPTH];
				sum   = mixed + (x0 ^ word_t'(r));
				fresh = rotl(sum, 8);
			end else begin
				mixed = rotl(x1, 8) ^ round_keys[r % RK_DEPTH];
				sum   = mixed + (x0 ^ word_t'(r));
				fresh = rotl(sum, 1);
			end
			x0 = x1;
			x1 = x2;
			x2 = x3;
			x3 = fresh;
		end
		c.cipher_word_0 = x0;
		c.cipher_word_1 = x1;
		c.cipher_word_2 = x2;
		c.cipher_word_3 = x3;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("checker: %s", msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// all-zero key gives an all-zero table
			for (int i = 0; i < RK_DEPTH; i++)
				round_keys[i] = '0;
			expected_ciphers.delete();
			errors         = 0;
			pending        = 0;
			blocks_checked = 0;
			key_writes     = 0;
		end else begin
			// a key word owns one lower-half and one upper-half table entry, the latter with index bit 0 swapped
			if (key_we) begin
				odd_slot = (int'(key_index) + KEY_WORDS) ^ 1;
				round_keys[key_index] = key_data ^ rotl(key_data, 1) ^ rotl(key_data, 8);
				round_keys[odd_slot]  = key_data ^ rotl(key_data, 1) ^ rotl(key_data, 11);
				key_writes++;
			end

			// returned word against the oldest prediction, field by field
			if (cipher_valid && cipher_ready) begin
				if (expected_ciphers.size() == 0) begin
					report_mismatch($sformatf("unexpected cipher word %h", cipher));
				end else begin
					want      = expected_ciphers.pop_front();
					got_bits  = cipher;
					want_bits = want;
					for (int f = 0; f < 4; f++)
						if (got_bits[BLOCK_W-1-WORD_W*f -: WORD_W] !==
						    want_bits[BLOCK_W-1-WORD_W*f -: WORD_W])
							report_mismatch($sformatf(
								"block %0d cipher_word_%0d got %h want %h",
								blocks_checked, f,
								got_bits[BLOCK_W-1-WORD_W*f -: WORD_W],
								want_bits[BLOCK_W-1-WORD_W*f -: WORD_W]));
					blocks_checked++;
				end
			end

			// accepted plaintext word: predict now, with the key as it stands
			if (plain_valid && plain_ready)
				expected_ciphers.push_back(encrypt_block(plain));

			pending = expected_ciphers.size();
		end
	end

endmodule

/* tb/sv/arx_block_cipher_64_128_encrypt_core_tb.sv */
// top of the testbench for the 64/128 arx cipher core: clock, reset, key settings,
// plaintext and ready stimulus, timeout and verdict
// depends on arxbc_pkg, arx_cipher_checker and the core rtl
`timescale 1ns / 1ps

module arx_block_cipher_64_128_encrypt_core_tb;
	import arxbc_pkg::*;

	localparam int ROUNDS      = 80;
	localparam int LIMIT       = 8_000_000;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 110;
	localparam int HOLD_CYCLES = 1500;
	localparam int HOLD_AFTER  = 300;

	logic              clk;
	logic              arst_n;
	logic              plain_valid;
	logic              plain_ready;
	plain_t            plain;
	logic              cipher_valid;
	logic              cipher_ready;
	cipher_t           cipher;
	logic              key_we;
	logic [KIDX_W-1:0] key_index;
	word_t             key_data;

	int errors;
	int pending;
	int blocks_checked;
	int key_writes;
	int key_settings;
	int cycles;
	bit calm;
	bit held_off;

	arx_block_cipher_64_128_encrypt_core #(
		.ROUNDS(ROUNDS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.plain_valid (plain_valid),
		.plain_ready (plain_ready),
		.plain       (plain),
		.cipher_valid(cipher_valid),
		.cipher_ready(cipher_ready),
		.cipher      (cipher),
		.key_we      (key_we),
		.key_index   (key_index),
		.key_data    (key_data)
	);

	arx_cipher_checker #(
		.ROUNDS(ROUNDS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.plain_valid   (plain_valid),
		.plain_ready   (plain_ready),
		.plain         (plain),
		.cipher_valid  (cipher_valid),
		.cipher_ready  (cipher_ready),
		.cipher        (cipher),
		.key_we        (key_we),
		.key_index     (key_index),
		.key_data      (key_data),
		.errors        (errors),
		.pending       (pending),
		.blocks_checked(blocks_checked),
		.key_writes    (key_writes)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(0, 2);
		else if (roll < 95)
			return $urandom_range(3, 30);
		return $urandom_range(100, 600);
	endfunction

	// random word with a bias toward the field extremes
	function automatic word_t pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_word(input plain_t p);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			plain_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		plain_valid = 1'b1;
		plain       = p;
		do
			@(posedge clk);
		while (!plain_ready);
		@(negedge clk);
	endtask

	task automatic write_keys(input word_t vals [KEY_WORDS], input logic [KEY_WORDS-1:0] mask);
		for (int i = 0; i < KEY_WORDS; i++) begin
			if (mask[i]) begin
				key_we    = 1'b1;
				key_index = KIDX_W'(i);
				key_data  = vals[i];
				@(negedge clk);
			end
		end
		key_we = 1'b0;
		key_settings++;
	endtask

	// end of a phase: every accepted word has come back, so the core is idle
	task automatic drain();
		plain_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off to back the core up
	initial begin
		int stall_left;
		stall_left   = 0;
		held_off     = 1'b0;
		cipher_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && blocks_checked >= HOLD_AFTER) begin
				held_off     = 1'b1;
				cipher_ready = 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end else if (calm) begin
				cipher_ready = 1'b1;
				stall_left   = 0;
			end else if (stall_left > 0) begin
				cipher_ready = 1'b0;
				stall_left--;
			end else begin
				cipher_ready = 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = pick_gap() + 1;
			end
		end
	end

	// timeout
	initial begin
		for (cycles = 0; cycles < LIMIT; cycles++)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		word_t              keys [KEY_WORDS];
		word_t              patterns [6];
		logic [KEY_WORDS-1:0] mask;
		plain_t             p;

		arst_n       = 1'b0;
		plain_valid  = 1'b0;
		plain        = '0;
		key_we       = 1'b0;
		key_index    = '0;
		key_data     = '0;
		calm         = 1'b0;
		key_settings = 1;
		patterns     = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset key: uniform patterns, one full field at a time, a mixed corner
		foreach (patterns[i])
			send_word('{patterns[i], patterns[i], patterns[i], patterns[i]});
		for (int f = 0; f < 4; f++) begin
			p = '0;
			p[4*WORD_W-1-WORD_W*f -: WORD_W] = 16'hFFFF;
			send_word(p);
		end
		send_word('{16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE});
		drain();

		// published test key and plaintext, plus the extremes under that key
		keys = '{16'h0100, 16'h0302, 16'h0504, 16'h0706,
		         16'h0908, 16'h0B0A, 16'h0D0C, 16'h0F0E};
		write_keys(keys, '1);
		send_word('{16'h1100, 16'h3322, 16'h5544, 16'h7766});
		send_word('0);
		send_word('1);
		drain();

		// random words under a sequence of key settings
		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 3 || ph == 7);
			mask = '1;
			case (ph)
				0: foreach (keys[i]) keys[i] = 16'hFFFF;
				1: foreach (keys[i]) keys[i] = 16'h0000;
				2: foreach (keys[i]) keys[i] = (i % 2 == 0) ? 16'h5555 : 16'hAAAA;
				4, 6, 8: begin
					// rewrite only some words: the core runs on a mixed key
					foreach (keys[i]) keys[i] = pick_word();
					mask = KEY_WORDS'($urandom_range(1, (1 << KEY_WORDS) - 2));
				end
				default: foreach (keys[i]) keys[i] = pick_word();
			endcase
			write_keys(keys, mask);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word('{pick_word(), pick_word(), pick_word(), pick_word()});
			drain();
		end
		calm = 1'b0;

		// let any stray word show up before the verdict
		repeat (4 * ROUNDS + 10) @(negedge clk);
		$display("tb: %0d blocks encrypted and checked under %0d key settings",
			blocks_checked, key_settings);
		$display("tb: %0d key word writes, %0d mismatches", key_writes, errors);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
